@@ rtl/mmf_pkg.sv @@
// Shared types, constants and helpers for the 3x3 min/max filter.
// No dependencies; every other file but mmf_ram refers to this package by scoped names.
`default_nettype none

package mmf_pkg;

    // Frame geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int FW_W      = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W     = 13;
    localparam int CFG_W_W   = 11;
    localparam int CFG_H_W   = 13;
    localparam int ROW_W     = 13;

    // Pixel layout: red [7:0], green [15:8], blue [23:16], alpha [31:24]
    localparam int CH_W  = 8;
    localparam int PIX_W = 4 * CH_W;
    localparam int ROW_STORE_W = 2 * PIX_W;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam int INFL_W     = 2;

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2
    } t_reg_idx;

    typedef enum logic {
        MODE_MIN = 1'b0,
        MODE_MAX = 1'b1
    } t_mode;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    // Which neighbours of the centre lie inside the frame
    typedef struct packed {
        logic up;
        logic down;
        logic left;
        logic right;
    } t_nbr;

    // One window step handed from the issue stage to the window datapath
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
        logic             emit;
        t_nbr             nbr;
        logic             frame_end;
        t_mode            mode;
    } t_step;

    typedef struct packed {
        logic active;
        logic extra;
    } t_issue_status;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            frame_end;
    } t_result;

    // Keep the smaller (minimum mode) or larger (maximum mode) value
    function automatic logic [CH_W-1:0] pick(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b,
                                             input t_mode mode);
        logic [CH_W-1:0] res;
        if (mode == MODE_MAX) begin
            res = (a > b) ? a : b;
        end else begin
            res = (a < b) ? a : b;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/mmf_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents.
`default_nettype none

module mmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/mmf_issue.sv @@
// Issue stage: frame position counters, frame latch and request acceptance.
// Uses mmf_pkg; turns each accepted request into at most two window steps.
`default_nettype none

module mmf_issue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [0:0]                    i_command,
    input  wire logic [mmf_pkg::PIX_W-1:0]     i_pixel,
    input  wire logic [mmf_pkg::CFG_W_W-1:0]   i_cfg_width,
    input  wire logic [mmf_pkg::CFG_H_W-1:0]   i_cfg_height,
    input  wire mmf_pkg::t_mode                i_cfg_mode,
    input  wire logic [mmf_pkg::FIFO_CW-1:0]   i_fifo_count,
    input  wire logic [mmf_pkg::INFL_W-1:0]    i_inflight,
    output logic                               o_ready,
    output logic                               o_issue,
    output mmf_pkg::t_step                     o_step,
    output mmf_pkg::t_issue_status             o_status
);

    logic                          r_active, n_active;
    logic                          r_extra, n_extra;
    logic [mmf_pkg::COL_W-1:0]     r_col, n_col;
    logic [mmf_pkg::ROW_W-1:0]     r_row, n_row;
    logic [mmf_pkg::FW_W-1:0]      r_fw;
    logic [mmf_pkg::CFG_H_W-1:0]   r_fh;
    mmf_pkg::t_mode                r_mode;

    logic [mmf_pkg::CMP_W-1:0]     cfg_w_wide;
    logic [mmf_pkg::CMP_W-1:0]     fw_wide;
    logic [mmf_pkg::FW_W-1:0]      fw_cfg;
    logic [mmf_pkg::CFG_H_W-1:0]   fh_cfg;
    logic [mmf_pkg::FIFO_CW:0]     credit_used;

    logic                          is_pixel;
    logic                          accept;
    logic                          start;
    logic [mmf_pkg::FW_W-1:0]      fw_e;
    logic [mmf_pkg::CFG_H_W-1:0]   fh_e;
    mmf_pkg::t_mode                mode_e;
    logic [mmf_pkg::COL_W-1:0]     col_e;
    logic [mmf_pkg::ROW_W-1:0]     row_e;
    logic [mmf_pkg::ROW_W:0]       row_x;
    logic [mmf_pkg::ROW_W:0]       fh_x;
    logic                          in_frame;
    logic                          item_step;
    logic                          emit_a;
    logic                          emit_b;
    logic [mmf_pkg::FW_W-1:0]      col_inc;
    logic                          wrap;

    // Clamp the configured geometry for a new frame
    always_comb begin
        cfg_w_wide = mmf_pkg::CMP_W'(i_cfg_width);
        if (cfg_w_wide == '0) begin
            fw_wide = mmf_pkg::CMP_W'(1);
        end else if (cfg_w_wide > mmf_pkg::CMP_W'(mmf_pkg::MAX_WIDTH)) begin
            fw_wide = mmf_pkg::CMP_W'(mmf_pkg::MAX_WIDTH);
        end else begin
            fw_wide = cfg_w_wide;
        end
        fw_cfg = fw_wide[mmf_pkg::FW_W-1:0];
        fh_cfg = (i_cfg_height == '0) ? mmf_pkg::CFG_H_W'(1) : i_cfg_height;
    end

    // Take a request only with no drain step pending and queue room for all in flight
    always_comb begin
        credit_used = (mmf_pkg::FIFO_CW + 1)'(i_fifo_count)
                    + (mmf_pkg::FIFO_CW + 1)'(i_inflight);
        o_ready = !r_extra
               && (credit_used < (mmf_pkg::FIFO_CW + 1)'(mmf_pkg::FIFO_DEPTH));
    end

    // Decide what the request does and describe the window step
    always_comb begin
        is_pixel = (mmf_pkg::t_cmd'(i_command) == mmf_pkg::CMD_PIXEL);
        accept   = i_valid && o_ready;
        start    = accept && is_pixel && !r_active;

        fw_e   = start ? fw_cfg     : r_fw;
        fh_e   = start ? fh_cfg     : r_fh;
        mode_e = start ? i_cfg_mode : r_mode;
        col_e  = start ? '0         : r_col;
        row_e  = start ? '0         : r_row;

        row_x    = (mmf_pkg::ROW_W + 1)'(row_e);
        fh_x     = (mmf_pkg::ROW_W + 1)'(fh_e);
        in_frame = (row_x < fh_x);

        item_step = accept && ((is_pixel && (start || in_frame))
                            || (!is_pixel && r_active && !in_frame));
        o_issue   = item_step || r_extra;

        // A column start closes the previous row; any later column closes the one before
        emit_a = (col_e == '0) && (row_e >= mmf_pkg::ROW_W'(2));
        emit_b = (col_e != '0) && (row_e >= mmf_pkg::ROW_W'(1));

        o_step.col  = col_e;
        o_step.pix  = (item_step && is_pixel) ? i_pixel : '0;
        o_step.emit = emit_a || emit_b;
        o_step.mode = mode_e;
        if (emit_a) begin
            o_step.nbr.up    = (row_e >= mmf_pkg::ROW_W'(3));
            o_step.nbr.down  = (row_x < fh_x + (mmf_pkg::ROW_W + 1)'(1));
            o_step.nbr.left  = (fw_e > mmf_pkg::FW_W'(1));
            o_step.nbr.right = 1'b0;
        end else begin
            o_step.nbr.up    = (row_e >= mmf_pkg::ROW_W'(2));
            o_step.nbr.down  = in_frame;
            o_step.nbr.left  = (col_e > mmf_pkg::COL_W'(1));
            o_step.nbr.right = 1'b1;
        end
        o_step.frame_end = emit_a && (row_x == fh_x + (mmf_pkg::ROW_W + 1)'(1));

        o_status.active = r_active;
        o_status.extra  = r_extra;
    end

    // Advance the raster position
    always_comb begin
        col_inc  = mmf_pkg::FW_W'(col_e) + mmf_pkg::FW_W'(1);
        wrap     = (col_inc == fw_e);
        n_active = r_active;
        n_col    = r_col;
        n_row    = r_row;
        if (o_issue) begin
            if (o_step.frame_end) begin
                n_active = 1'b0;
                n_col    = '0;
                n_row    = '0;
            end else begin
                n_active = 1'b1;
                n_col    = wrap ? '0 : col_inc[mmf_pkg::COL_W-1:0];
                n_row    = wrap ? row_e + mmf_pkg::ROW_W'(1) : row_e;
            end
        end
        // A drain that closes nothing needs a second step
        n_extra = item_step && !is_pixel && !o_step.emit;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_extra  <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_active <= n_active;
            r_extra  <= n_extra;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    // Latch frame geometry and mode at the first pixel
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_fw   <= fw_cfg;
            r_fh   <= fh_cfg;
            r_mode <= i_cfg_mode;
        end
    end

endmodule

`default_nettype wire

@@ rtl/mmf_window.sv @@
// Window datapath: two-row store RAM with forwarding, 3x3 window, min/max.
// Uses mmf_pkg and mmf_ram; takes steps from mmf_issue, pushes results to the queue.
`default_nettype none

module mmf_window (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_issue,
    input  wire mmf_pkg::t_step               i_step,
    output logic                              o_push,
    output mmf_pkg::t_result                  o_result,
    output logic [mmf_pkg::INFL_W-1:0]        o_inflight
);

    logic                                r_s1_valid;
    mmf_pkg::t_step                      r_s1;
    logic                                r_fwd_hit;
    logic [mmf_pkg::ROW_STORE_W-1:0]     r_fwd_data;
    logic                                r_s2_valid;
    mmf_pkg::t_nbr                       r_s2_nbr;
    logic                                r_s2_end;
    mmf_pkg::t_mode                      r_s2_mode;
    logic [mmf_pkg::PIX_W-1:0]           r_win [3][3];

    logic [mmf_pkg::ROW_STORE_W-1:0]     ram_rdata;
    logic [mmf_pkg::ROW_STORE_W-1:0]     s1_rd;
    logic [mmf_pkg::ROW_STORE_W-1:0]     s1_wdata;
    logic [mmf_pkg::PIX_W-1:0]           s1_column [3];
    logic                                n_fwd_hit;
    logic [2:0]                          row_ok;
    logic [2:0]                          col_ok;
    logic [mmf_pkg::CH_W-1:0]            cand [3][9];
    logic [mmf_pkg::CH_W-1:0]            lvl1 [3][4];
    logic [mmf_pkg::CH_W-1:0]            lvl2 [3][2];
    logic [mmf_pkg::CH_W-1:0]            acc [3];

    // Row store word: upper half is the previous row, lower half the one before
    mmf_ram #(
        .WIDTH (mmf_pkg::ROW_STORE_W),
        .DEPTH (mmf_pkg::MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1.col),
        .i_wdata (s1_wdata),
        .i_re    (i_issue),
        .i_raddr (i_step.col),
        .o_rdata (ram_rdata)
    );

    // Forward the word written in the same cycle as a read of that column
    always_comb begin
        s1_rd        = r_fwd_hit ? r_fwd_data : ram_rdata;
        s1_column[0] = s1_rd[mmf_pkg::PIX_W-1:0];
        s1_column[1] = s1_rd[mmf_pkg::ROW_STORE_W-1:mmf_pkg::PIX_W];
        s1_column[2] = r_s1.pix;
        s1_wdata     = {r_s1.pix, s1_column[1]};
        n_fwd_hit    = i_issue && r_s1_valid && (i_step.col == r_s1.col);
        o_inflight   = mmf_pkg::INFL_W'(r_s1_valid && r_s1.emit)
                     + mmf_pkg::INFL_W'(r_s2_valid);
    end

    // Advance pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_issue;
            r_fwd_hit  <= n_fwd_hit;
            r_s2_valid <= r_s1_valid && r_s1.emit;
        end
    end

    // Capture step payload and shift the window by one column
    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s1 <= i_step;
        end
        r_fwd_data <= s1_wdata;
        if (r_s1_valid) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
                r_win[i][2] <= s1_column[i];
            end
            r_s2_nbr  <= r_s1.nbr;
            r_s2_end  <= r_s1.frame_end;
            r_s2_mode <= r_s1.mode;
        end
    end

    // Reduce per colour channel as a balanced tree; out-of-frame places take the centre
    always_comb begin
        row_ok = {r_s2_nbr.down, 1'b1, r_s2_nbr.up};
        col_ok = {r_s2_nbr.right, 1'b1, r_s2_nbr.left};
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    cand[ch][i*3+j] = (row_ok[i] && col_ok[j])
                        ? r_win[i][j][ch*mmf_pkg::CH_W +: mmf_pkg::CH_W]
                        : r_win[1][1][ch*mmf_pkg::CH_W +: mmf_pkg::CH_W];
                end
            end
            for (int k = 0; k < 4; k++) begin
                lvl1[ch][k] = mmf_pkg::pick(cand[ch][2*k], cand[ch][2*k+1], r_s2_mode);
            end
            for (int k = 0; k < 2; k++) begin
                lvl2[ch][k] = mmf_pkg::pick(lvl1[ch][2*k], lvl1[ch][2*k+1], r_s2_mode);
            end
            acc[ch] = mmf_pkg::pick(mmf_pkg::pick(lvl2[ch][0], lvl2[ch][1], r_s2_mode),
                                    cand[ch][8], r_s2_mode);
        end
        o_push             = r_s2_valid;
        o_result.red       = acc[0];
        o_result.green     = acc[1];
        o_result.blue      = acc[2];
        o_result.alpha     = r_win[1][1][mmf_pkg::PIX_W-1 -: mmf_pkg::CH_W];
        o_result.frame_end = r_s2_end;
    end

endmodule

`default_nettype wire

@@ rtl/mmf_out_fifo.sv @@
// Output queue for filtered pixels; parts the datapath from the result channel.
// Uses mmf_pkg for the result type and depth.
`default_nettype none

module mmf_out_fifo (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire mmf_pkg::t_result            i_data,
    input  wire logic                        i_ready,
    output logic                             o_valid,
    output mmf_pkg::t_result                 o_data,
    output logic [mmf_pkg::FIFO_CW-1:0]      o_count
);

    mmf_pkg::t_result                r_slot [mmf_pkg::FIFO_DEPTH];
    logic [mmf_pkg::FIFO_AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [mmf_pkg::FIFO_AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [mmf_pkg::FIFO_CW-1:0]     r_count, n_count;
    logic                            pop;

    // Pointer and occupancy update
    always_comb begin
        o_valid  = (r_count != '0);
        o_data   = r_slot[r_rd_ptr];
        o_count  = r_count;
        pop      = o_valid && i_ready;
        n_wr_ptr = i_push ? r_wr_ptr + mmf_pkg::FIFO_AW'(1) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + mmf_pkg::FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count + mmf_pkg::FIFO_CW'(i_push) - mmf_pkg::FIFO_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/min_max_filter_3x3.sv @@
// Top level of the 3x3 per-channel min/max filter with its APB register bank.
// Uses mmf_pkg, mmf_issue, mmf_window (with mmf_ram) and mmf_out_fifo.
//
// Channel   | Dir | Handshake             | Payload
// pixels    | in  | i_valid / o_ready     | i_command, i_in_red/green/blue/alpha
// results   | out | o_valid / i_ready     | o_out_red/green/blue/alpha, o_frame_end
// registers | in  | psel, penable, pready | paddr, pwrite, pwdata, prdata
//
// One request per cycle while o_ready is high; a result enters the four-entry output queue
// once the row store RAM read and the window update have been registered.
// The first drain of a one-row frame issues a second step, with o_ready low while it does.
// Otherwise o_ready falls only when queued plus in-flight results fill the queue.
// Synchronous reset clears control state; the row store is not cleared.
`default_nettype none

module min_max_filter_3x3 (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [0:0]                   i_command,
    input  wire logic [mmf_pkg::CH_W-1:0]     i_in_red,
    input  wire logic [mmf_pkg::CH_W-1:0]     i_in_green,
    input  wire logic [mmf_pkg::CH_W-1:0]     i_in_blue,
    input  wire logic [mmf_pkg::CH_W-1:0]     i_in_alpha,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [mmf_pkg::CH_W-1:0]          o_out_red,
    output logic [mmf_pkg::CH_W-1:0]          o_out_green,
    output logic [mmf_pkg::CH_W-1:0]          o_out_blue,
    output logic [mmf_pkg::CH_W-1:0]          o_out_alpha,
    output logic [0:0]                        o_frame_end,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mmf_pkg::APB_AW-1:0]   paddr,
    input  wire logic [mmf_pkg::APB_DW-1:0]   pwdata,
    output logic [mmf_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    logic [mmf_pkg::CFG_W_W-1:0]   r_cfg_width;
    logic [mmf_pkg::CFG_H_W-1:0]   r_cfg_height;
    mmf_pkg::t_mode                r_cfg_mode;

    logic                          apb_write;
    mmf_pkg::t_reg_idx             reg_idx;
    logic [mmf_pkg::PIX_W-1:0]     pixel;
    logic                          issue;
    mmf_pkg::t_step                step;
    mmf_pkg::t_issue_status        status;
    logic                          push;
    mmf_pkg::t_result              result;
    mmf_pkg::t_result              head;
    logic [mmf_pkg::INFL_W-1:0]    inflight;
    logic [mmf_pkg::FIFO_CW-1:0]   fifo_count;

    // Register bank access
    always_comb begin
        pready    = 1'b1;
        apb_write = psel && penable && pwrite && pready;
        reg_idx   = mmf_pkg::t_reg_idx'(paddr[3:2]);
        unique case (reg_idx)
            mmf_pkg::REG_WIDTH:  prdata = mmf_pkg::APB_DW'(r_cfg_width);
            mmf_pkg::REG_HEIGHT: prdata = mmf_pkg::APB_DW'(r_cfg_height);
            mmf_pkg::REG_MODE:   prdata = mmf_pkg::APB_DW'(r_cfg_mode);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= mmf_pkg::CFG_W_W'(1024);
            r_cfg_height <= mmf_pkg::CFG_H_W'(1024);
            r_cfg_mode   <= mmf_pkg::MODE_MIN;
        end else if (apb_write) begin
            unique case (reg_idx)
                mmf_pkg::REG_WIDTH:  r_cfg_width  <= pwdata[mmf_pkg::CFG_W_W-1:0];
                mmf_pkg::REG_HEIGHT: r_cfg_height <= pwdata[mmf_pkg::CFG_H_W-1:0];
                mmf_pkg::REG_MODE:   r_cfg_mode   <= mmf_pkg::t_mode'(pwdata[0]);
                default: ;
            endcase
        end
    end

    assign pixel = {i_in_alpha, i_in_blue, i_in_green, i_in_red};

    mmf_issue u_issue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_command    (i_command),
        .i_pixel      (pixel),
        .i_cfg_width  (r_cfg_width),
        .i_cfg_height (r_cfg_height),
        .i_cfg_mode   (r_cfg_mode),
        .i_fifo_count (fifo_count),
        .i_inflight   (inflight),
        .o_ready      (o_ready),
        .o_issue      (issue),
        .o_step       (step),
        .o_status     (status)
    );

    mmf_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_issue    (issue),
        .i_step     (step),
        .o_push     (push),
        .o_result   (result),
        .o_inflight (inflight)
    );

    mmf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (head),
        .o_count (fifo_count)
    );

    assign o_out_red   = head.red;
    assign o_out_green = head.green;
    assign o_out_blue  = head.blue;
    assign o_out_alpha = head.alpha;
    assign o_frame_end = head.frame_end;

    // Queued and in-flight results never exceed the queue depth
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((mmf_pkg::FIFO_CW + 1)'(fifo_count) + (mmf_pkg::FIFO_CW + 1)'(inflight))
            <= (mmf_pkg::FIFO_CW + 1)'(mmf_pkg::FIFO_DEPTH))
        else $error("output queue overcommitted");

    // The second step of a drain blocks new requests
    a_extra_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.extra |-> (!o_ready && issue))
        else $error("extra drain step not issued alone");

    // The step that closes a frame leaves the block idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && step.frame_end) |=> (!status.active && !status.extra))
        else $error("frame still active after its last result");

    // A closing step always carries a result
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && step.frame_end) |-> step.emit)
        else $error("frame end without a result");

endmodule

`default_nettype wire

@@ dv/tb_min_max_filter_3x3.sv @@
// Self-checking testbench for min_max_filter_3x3: random RGBA frames and drain requests
// go in, and every filtered pixel that comes out is checked against a predictor.
// Depends on rtl/mmf_pkg.sv and the filter RTL only.

module tb_min_max_filter_3x3;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_TARGET  = 450;
    localparam int MAX_SHOWN      = 10;

    // Predicts the filtered pixels and holds those still owed by the block
    class filtered_pixel_board;
        logic [mmf_pkg::PIX_W-1:0]   row_prev  [mmf_pkg::MAX_WIDTH];
        logic [mmf_pkg::PIX_W-1:0]   row_prev2 [mmf_pkg::MAX_WIDTH];
        logic [mmf_pkg::PIX_W-1:0]   window    [9];
        int unsigned                 in_col, in_row, out_count;
        logic [mmf_pkg::CFG_W_W-1:0] reg_width;
        logic [mmf_pkg::CFG_H_W-1:0] reg_height;
        mmf_pkg::t_mode              reg_mode;
        int unsigned                 frame_w, frame_h;
        mmf_pkg::t_mode              frame_mode;
        bit                          frame_running;
        mmf_pkg::t_result            due_pixels [$];
        int unsigned                 mismatches, matched, frames;

        function new();
            foreach (row_prev[i]) begin
                row_prev[i]  = '0;
                row_prev2[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            in_col        = 0;
            in_row        = 0;
            out_count     = 0;
            reg_width     = 11'd1024;
            reg_height    = 13'd1024;
            reg_mode      = mmf_pkg::MODE_MIN;
            frame_w       = 1;
            frame_h       = 1;
            frame_mode    = mmf_pkg::MODE_MIN;
            frame_running = 1'b0;
            mismatches    = 0;
            matched       = 0;
            frames        = 0;
        endfunction

        function void write_reg(mmf_pkg::t_reg_idx idx, logic [mmf_pkg::APB_DW-1:0] value);
            case (idx)
                mmf_pkg::REG_WIDTH:  reg_width  = value[mmf_pkg::CFG_W_W-1:0];
                mmf_pkg::REG_HEIGHT: reg_height = value[mmf_pkg::CFG_H_W-1:0];
                mmf_pkg::REG_MODE:   reg_mode   = mmf_pkg::t_mode'(value[0]);
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function bit pixels_complete();
            return frame_running && (in_row * frame_w + in_col >= frame_w * frame_h);
        endfunction

        // Min or max over the in-frame part of the window around (orow, ocol)
        function mmf_pkg::t_result neighbourhood(int orow, int ocol, int cc);
            mmf_pkg::t_result         res;
            logic [mmf_pkg::CH_W-1:0] acc [3];
            logic [mmf_pkg::CH_W-1:0] v;
            int                       nr, nc, dc;
            for (int ch = 0; ch < 3; ch++)
                acc[ch] = (frame_mode == mmf_pkg::MODE_MAX) ? 8'h00 : 8'hFF;
            for (int i = 0; i < 3; i++) begin
                nr = orow + i - 1;
                if (nr < 0 || nr >= int'(frame_h)) continue;
                for (int j = 0; j < 3; j++) begin
                    dc = j - cc;
                    nc = ocol + dc;
                    if (dc < -1 || nc < 0 || nc >= int'(frame_w)) continue;
                    for (int ch = 0; ch < 3; ch++) begin
                        v = window[i * 3 + j][8 * ch +: 8];
                        if ((frame_mode == mmf_pkg::MODE_MAX) ? (v > acc[ch]) : (v < acc[ch]))
                            acc[ch] = v;
                    end
                end
            end
            res.red       = acc[0];
            res.green     = acc[1];
            res.blue      = acc[2];
            res.alpha     = window[3 + cc][31:24];
            res.frame_end = (out_count == frame_w * frame_h - 1);
            out_count++;
            return res;
        endfunction

        // Advance the window by one column; returns whether a pixel falls out
        function bit window_step(logic [mmf_pkg::PIX_W-1:0] pix);
            logic [mmf_pkg::PIX_W-1:0] column [3];
            mmf_pkg::t_result          res;
            bit                        gave;
            int unsigned               c, r;
            c         = in_col % mmf_pkg::MAX_WIDTH;
            r         = in_row;
            gave      = 1'b0;
            column[0] = row_prev2[c];
            column[1] = row_prev[c];
            column[2] = pix;
            // last pixel of the row two rows up leaves before the shift
            if (c == 0 && r >= 2) begin
                res  = neighbourhood(r - 2, frame_w - 1, 2);
                gave = 1'b1;
            end
            for (int i = 0; i < 3; i++) begin
                window[i * 3 + 0] = window[i * 3 + 1];
                window[i * 3 + 1] = window[i * 3 + 2];
                window[i * 3 + 2] = column[i];
            end
            row_prev2[c] = column[1];
            row_prev[c]  = pix;
            if (c >= 1 && r >= 1) begin
                res  = neighbourhood(r - 1, c - 1, 1);
                gave = 1'b1;
            end
            in_col = c + 1;
            if (in_col >= frame_w) begin
                in_col = 0;
                in_row++;
            end
            if (gave) begin
                due_pixels.push_back(res);
                if (res.frame_end) begin
                    in_col        = 0;
                    in_row        = 0;
                    out_count     = 0;
                    frame_running = 1'b0;
                end
            end
            return gave;
        endfunction

        function void note_request(mmf_pkg::t_cmd cmd, logic [mmf_pkg::PIX_W-1:0] pix);
            // latch the geometry and mode at the first pixel of a frame
            if (cmd == mmf_pkg::CMD_PIXEL && !frame_running) begin
                frame_w = (reg_width == 0) ? 1 : reg_width;
                if (frame_w > mmf_pkg::MAX_WIDTH) frame_w = mmf_pkg::MAX_WIDTH;
                frame_h       = (reg_height == 0) ? 1 : reg_height;
                frame_mode    = reg_mode;
                in_col        = 0;
                in_row        = 0;
                out_count     = 0;
                frame_running = 1'b1;
                frames++;
            end
            if (!frame_running) return;
            if (cmd == mmf_pkg::CMD_PIXEL) begin
                // drop pixels that arrive while the frame is draining
                if (!pixels_complete()) void'(window_step(pix));
                return;
            end
            // drop drains that come before the frame is complete
            if (!pixels_complete()) return;
            // a one-row frame needs an idle step before its first pixel leaves
            if (!window_step('0)) void'(window_step('0));
        endfunction

        function void check_result(mmf_pkg::t_result got);
            mmf_pkg::t_result want;
            if (due_pixels.size() == 0) begin
                flag($sformatf("unexpected pixel r=%h g=%h b=%h a=%h end=%b",
                               got.red, got.green, got.blue, got.alpha, got.frame_end));
                return;
            end
            want = due_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.alpha !== want.alpha || got.frame_end !== want.frame_end)
                flag($sformatf({"expected r=%h g=%h b=%h a=%h end=%b, ",
                                "got r=%h g=%h b=%h a=%h end=%b"},
                               want.red, want.green, want.blue, want.alpha, want.frame_end,
                               got.red, got.green, got.blue, got.alpha, got.frame_end));
            else
                matched++;
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n        = 1'b0;
    logic                         i_valid        = 1'b0;
    logic                         o_ready;
    logic [0:0]                   i_command      = mmf_pkg::CMD_PIXEL;
    logic [mmf_pkg::CH_W-1:0]     i_in_red       = '0;
    logic [mmf_pkg::CH_W-1:0]     i_in_green     = '0;
    logic [mmf_pkg::CH_W-1:0]     i_in_blue      = '0;
    logic [mmf_pkg::CH_W-1:0]     i_in_alpha     = '0;
    logic                         o_valid;
    logic                         i_ready        = 1'b0;
    logic [mmf_pkg::CH_W-1:0]     o_out_red;
    logic [mmf_pkg::CH_W-1:0]     o_out_green;
    logic [mmf_pkg::CH_W-1:0]     o_out_blue;
    logic [mmf_pkg::CH_W-1:0]     o_out_alpha;
    logic [0:0]                   o_frame_end;
    logic                         psel           = 1'b0;
    logic                         penable        = 1'b0;
    logic                         pwrite         = 1'b0;
    logic [mmf_pkg::APB_AW-1:0]   paddr          = '0;
    logic [mmf_pkg::APB_DW-1:0]   pwdata         = '0;
    logic [mmf_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    filtered_pixel_board board;
    int unsigned         tx_gap_pct     = 20;
    int unsigned         sink_stall_pct = 20;
    int unsigned         requests_sent  = 0;
    int unsigned         frame_requests = 0;
    int unsigned         quiet_cycles   = 0;

    min_max_filter_3x3 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_in_alpha  (i_in_alpha),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_frame_end (o_frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic bit chance(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned gap_len();
        return ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    // Random RGBA with the channel extremes well represented
    function automatic logic [mmf_pkg::PIX_W-1:0] rand_pixel();
        logic [mmf_pkg::PIX_W-1:0] px;
        px = $urandom;
        for (int ch = 0; ch < 4; ch++) begin
            case ($urandom_range(7))
                0: px[8 * ch +: 8] = 8'h00;
                1: px[8 * ch +: 8] = 8'hFF;
                default: ;
            endcase
        end
        return px;
    endfunction

    // Hold one request until accepted; returns at a falling edge with valid still high
    task automatic send_request(input mmf_pkg::t_cmd cmd,
                                input logic [mmf_pkg::PIX_W-1:0] pix);
        int unsigned gap;
        gap = chance(tx_gap_pct) ? gap_len() : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_in_red   <= pix[7:0];
        i_in_green <= pix[15:8];
        i_in_blue  <= pix[23:16];
        i_in_alpha <= pix[31:24];
        do @(posedge i_clk); while (!o_ready);
        board.note_request(cmd, pix);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Stop sending and let every owed pixel come out, plus the pipeline latency
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (board.due_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register, then read it back
    task automatic set_reg(input mmf_pkg::t_reg_idx idx,
                           input logic [mmf_pkg::APB_DW-1:0] value);
        logic [mmf_pkg::APB_DW-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            mmf_pkg::REG_WIDTH:  want = value & ((32'd1 << mmf_pkg::CFG_W_W) - 1);
            mmf_pkg::REG_HEIGHT: want = value & ((32'd1 << mmf_pkg::CFG_H_W) - 1);
            mmf_pkg::REG_MODE:   want = value & 32'd1;
            default:             want = '0;
        endcase
        if (prdata !== want)
            board.flag($sformatf("register %s read %h, expected %h", idx.name(), prdata, want));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h,
                             input mmf_pkg::t_mode mode);
        wait_idle();
        set_reg(mmf_pkg::REG_WIDTH, w);
        set_reg(mmf_pkg::REG_HEIGHT, h);
        set_reg(mmf_pkg::REG_MODE, 32'(mode));
    endtask

    // One whole frame: pixels, then drains until the frame end, with optional noise
    task automatic run_frame(input int unsigned noise_pct);
        do begin
            if (chance(noise_pct)) send_request(mmf_pkg::CMD_DRAIN, rand_pixel());
            send_request(mmf_pkg::CMD_PIXEL, rand_pixel());
            frame_requests++;
        end while (!board.pixels_complete());
        while (board.frame_running) begin
            if (chance(noise_pct)) begin
                send_request(mmf_pkg::CMD_PIXEL, rand_pixel());
            end else begin
                send_request(mmf_pkg::CMD_DRAIN, rand_pixel());
                frame_requests++;
            end
        end
        if (chance(noise_pct * 3)) send_request(mmf_pkg::CMD_DRAIN, rand_pixel());
    endtask

    // Result side: random back-pressure in stretches
    initial begin : result_sink
        int unsigned hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold == 0 && chance(sink_stall_pct)) hold = gap_len();
            if (hold != 0) begin
                i_ready <= 1'b0;
                hold--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        mmf_pkg::t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.red       = o_out_red;
            got.green     = o_out_green;
            got.blue      = o_out_blue;
            got.alpha     = o_out_alpha;
            got.frame_end = o_frame_end;
            board.check_result(got);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** min_max_filter_3x3: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned start_count;
        int unsigned w, h;
        board = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: 3x3 frame with extreme pixels and every kind of stray request
        tx_gap_pct     = 0;
        sink_stall_pct = 0;
        set_reg(mmf_pkg::REG_WIDTH, 3);
        set_reg(mmf_pkg::REG_HEIGHT, 3);
        set_reg(mmf_pkg::REG_MODE, 32'(mmf_pkg::MODE_MIN));
        send_request(mmf_pkg::CMD_DRAIN, 32'hFFFF_FFFF);
        send_request(mmf_pkg::CMD_PIXEL, 32'hFFFF_FFFF);
        send_request(mmf_pkg::CMD_PIXEL, 32'h0000_0000);
        // hold the sender until all is quiet, then change mode mid-frame
        wait_idle();
        set_reg(mmf_pkg::REG_MODE, 32'(mmf_pkg::MODE_MAX));
        send_request(mmf_pkg::CMD_PIXEL, 32'h00FF_00FF);
        send_request(mmf_pkg::CMD_PIXEL, 32'hFF00_FF00);
        send_request(mmf_pkg::CMD_PIXEL, 32'h8001_7F80);
        send_request(mmf_pkg::CMD_DRAIN, 32'h0000_0000);
        send_request(mmf_pkg::CMD_PIXEL, 32'h7F80_01FE);
        send_request(mmf_pkg::CMD_PIXEL, 32'hA5A5_5A5A);
        send_request(mmf_pkg::CMD_PIXEL, 32'h0102_0408);
        send_request(mmf_pkg::CMD_PIXEL, 32'hFEFD_FBF7);
        send_request(mmf_pkg::CMD_DRAIN, 32'h0000_0000);
        send_request(mmf_pkg::CMD_PIXEL, 32'h1234_5678);
        while (board.frame_running) send_request(mmf_pkg::CMD_DRAIN, 32'hFFFF_FFFF);
        send_request(mmf_pkg::CMD_DRAIN, 32'h0000_0000);
        // one-row frame in maximum mode
        configure(2, 1, mmf_pkg::MODE_MAX);
        run_frame(0);

        // Random frames, mostly small, some back to back
        start_count = frame_requests;
        while (frame_requests - start_count < RANDOM_TARGET) begin
            if (chance(60)) begin
                case ($urandom_range(9))
                    0:       w = 0;
                    1, 2:    w = $urandom_range(7, 40);
                    default: w = $urandom_range(1, 6);
                endcase
                case ($urandom_range(9))
                    0:       h = 0;
                    1, 2:    h = $urandom_range(6, 12);
                    default: h = $urandom_range(1, 5);
                endcase
                configure(w, h, mmf_pkg::t_mode'($urandom_range(1)));
            end
            case ($urandom_range(2))
                0:       tx_gap_pct = 0;
                1:       tx_gap_pct = 15;
                default: tx_gap_pct = 50;
            endcase
            case ($urandom_range(2))
                0:       sink_stall_pct = 0;
                1:       sink_stall_pct = 15;
                default: sink_stall_pct = 50;
            endcase
            run_frame(8);
        end

        // Corner sizes: zero width and height read as one, then a tall single column
        tx_gap_pct     = 10;
        sink_stall_pct = 10;
        configure(0, 0, mmf_pkg::MODE_MIN);
        run_frame(2);
        configure(1, 30, mmf_pkg::MODE_MAX);
        run_frame(2);

        wait_idle();
        $display("Run covered %0d requests in %0d frames: widths 0 to 40, heights 0 to 30,",
                 requests_sent, board.frames);
        $display("both modes, stray drains and pixels; %0d pixels checked, %0d mismatches.",
                 board.matched, board.mismatches);
        if (board.mismatches == 0 && board.due_pixels.size() == 0)
            $display("** min_max_filter_3x3: PASSED **");
        else
            $display("** min_max_filter_3x3: FAILED **");
        $finish;
    end

endmodule
